### hw/rtl/tsfc_pkg.sv
// ----------------------------------------------------------------------------
// tsfc_pkg
// Shared widths, opcodes, register indexes and types of the thermal step
// frequency cap unit.
// ----------------------------------------------------------------------------
package tsfc_pkg;

  // fixed field widths
  localparam int FREQ_W     = 22;
  localparam int LEVEL_W    = 4;
  localparam int THR_W      = 16;
  localparam int STEP_W     = 15;
  localparam int FLOOR_W    = 4;
  localparam int OPCODE_W   = 2;
  localparam int ENTRY_W    = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // item opcodes
  localparam logic [OPCODE_W-1:0] OP_SAMPLE = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_NEWCAP = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_REEVAL = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_WRITE  = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOOR     = 2'd3;

  typedef logic [FREQ_W-1:0] freq_t;
  typedef logic [STEP_W-1:0] step_t;

endpackage

### hw/rtl/tsfc_ram.sv
// ----------------------------------------------------------------------------
// tsfc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tsfc_ram #(
  parameter int WIDTH = 22,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/tsfc_div.sv
// ----------------------------------------------------------------------------
// tsfc_div
// Restoring divider, one quotient bit per cycle, nonnegative dividend.
// ----------------------------------------------------------------------------
module tsfc_div #(
  parameter int DW = 17
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DW-1:0]        dividend,
  input  tsfc_pkg::step_t      divisor,
  output logic                 done,
  output logic [DW-1:0]        quotient
);

  localparam int CW = $clog2(DW + 1);
  localparam int SW = tsfc_pkg::STEP_W;

  logic          busy;
  logic [CW-1:0] cnt;
  logic [SW-1:0] rem;
  logic [SW:0]   trial;
  logic          ge;
  logic [SW:0]   diff;

  // one trial subtraction per cycle
  assign trial = {rem, quotient[DW-1]};
  assign ge    = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};

  // iteration control and shift registers
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CW'(1);
        if (cnt == CW'(DW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // remainder and quotient, no reset needed
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= ge ? diff[SW-1:0] : trial[SW-1:0];
      quotient <= {quotient[DW-2:0], ge};
    end
  end

endmodule

### hw/rtl/thermal_step_frequency_cap_unit.sv
// A table write takes effect on its input transfer. A temperature sample or
// re-evaluate at or above threshold runs the DW-bit serial divider (DW =
// max(TEMP_WIDTH, 16) + 1); a new cap first searches the table entry by entry
// through the single table read port, then re-evaluates.
// One item at a time: in_ready is high only when idle.
// Reset clears control and configuration state; table contents stay undefined.
// ----------------------------------------------------------------------------
// thermal_step_frequency_cap_unit
// Steps a cluster frequency cap down a sorted table as temperature rises,
// using one shared serial divider and one table read port under a sequencer.
// ----------------------------------------------------------------------------
module thermal_step_frequency_cap_unit #(
  parameter int TABLE_DEPTH = 16,
  parameter int TEMP_WIDTH  = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration
  input  logic                                cfg_we,
  input  logic [tsfc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tsfc_pkg::CFG_DATA_W-1:0]     cfg_data,
  // input items
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [tsfc_pkg::OPCODE_W-1:0]       opcode,
  input  logic signed [TEMP_WIDTH-1:0]        temperature,
  input  tsfc_pkg::freq_t                     freq_khz,
  input  logic [tsfc_pkg::ENTRY_W-1:0]        entry_index,
  // result items
  output logic                                out_valid,
  input  logic                                out_ready,
  output tsfc_pkg::freq_t                     cap_freq,
  output logic [tsfc_pkg::LEVEL_W-1:0]        cap_level
);

  localparam int LW   = $clog2(TABLE_DEPTH);
  localparam int TMAX = (TEMP_WIDTH > tsfc_pkg::THR_W) ? TEMP_WIDTH : tsfc_pkg::THR_W;
  localparam int DW   = TMAX + 1;

  // sequencer states
  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_REEVAL   = 3'd1;
  localparam logic [2:0] S_SRCH_RD  = 3'd2;
  localparam logic [2:0] S_SRCH_CHK = 3'd3;
  localparam logic [2:0] S_DIV      = 3'd4;
  localparam logic [2:0] S_LVL      = 3'd5;
  localparam logic [2:0] S_RD       = 3'd6;
  localparam logic [2:0] S_OUT      = 3'd7;

  // configuration registers
  logic                               enable;
  logic signed [tsfc_pkg::THR_W-1:0]  throttle_threshold;
  tsfc_pkg::step_t                    temp_step;
  logic [tsfc_pkg::FLOOR_W-1:0]       floor_level;

  // governor state
  logic [2:0]                   state;
  logic [LW-1:0]                current_level;
  logic [LW-1:0]                top_level;
  tsfc_pkg::freq_t              applied_cap;
  logic signed [TEMP_WIDTH-1:0] last_temperature;
  logic [LW-1:0]                lvl;
  logic [LW-1:0]                sidx;
  tsfc_pkg::freq_t              cap_reg;
  logic                         use_floor;

  logic                         accept;
  logic                         ram_we;
  logic [LW-1:0]                raddr;
  tsfc_pkg::freq_t              rdata;
  logic signed [TEMP_WIDTH-1:0] temp_sel;
  logic signed [DW-1:0]         diff;
  logic                         diff_neg;
  logic                         sample_go;
  logic                         div_start;
  logic                         div_done;
  logic [DW-1:0]                quotient;
  tsfc_pkg::step_t              step_eff;
  logic                         emit;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid & in_ready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      enable             <= 1'b0;
      throttle_threshold <= '0;
      temp_step          <= tsfc_pkg::STEP_W'(1);
      floor_level        <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        tsfc_pkg::CFG_ENABLE:    enable             <= cfg_data[0];
        tsfc_pkg::CFG_THRESHOLD: throttle_threshold <= signed'(cfg_data[tsfc_pkg::THR_W-1:0]);
        tsfc_pkg::CFG_STEP:      temp_step          <= cfg_data[tsfc_pkg::STEP_W-1:0];
        tsfc_pkg::CFG_FLOOR:     floor_level        <= cfg_data[tsfc_pkg::FLOOR_W-1:0];
        default: ;
      endcase
    end
  end

  // shared subtractor: new sample when idle, last sample otherwise
  assign temp_sel  = (state == S_IDLE) ? temperature : last_temperature;
  assign diff      = DW'(temp_sel) - DW'(throttle_threshold);
  assign diff_neg  = diff[DW-1];
  assign step_eff  = (temp_step == '0) ? tsfc_pkg::STEP_W'(1) : temp_step;

  assign sample_go = accept && (opcode == tsfc_pkg::OP_SAMPLE) && enable &&
                     (temperature != last_temperature);
  assign div_start = (sample_go || (state == S_REEVAL)) && !diff_neg;

  // level change decision, floor only for a sample at or above threshold
  assign emit = (lvl != current_level) &&
                !(use_floor && (32'(current_level) < 32'(floor_level)));

  // table write straight from the input transfer
  assign ram_we = accept && (opcode == tsfc_pkg::OP_WRITE) &&
                  (32'(entry_index) < TABLE_DEPTH);
  assign raddr  = (state == S_SRCH_RD) ? sidx : lvl;

  tsfc_ram #(
    .WIDTH (tsfc_pkg::FREQ_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (LW'(entry_index)),
    .wdata (freq_khz),
    .raddr (raddr),
    .rdata (rdata)
  );

  tsfc_div #(
    .DW (DW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (diff),
    .divisor  (step_eff),
    .done     (div_done),
    .quotient (quotient)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      current_level    <= '0;
      top_level        <= '0;
      applied_cap      <= '0;
      last_temperature <= '0;
      use_floor        <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (opcode)
              tsfc_pkg::OP_SAMPLE: begin
                if (sample_go) begin
                  last_temperature <= temperature;
                  use_floor        <= !diff_neg;
                  lvl              <= top_level;
                  state            <= diff_neg ? S_LVL : S_DIV;
                end
              end
              tsfc_pkg::OP_NEWCAP: begin
                if (freq_khz != applied_cap) begin
                  cap_reg <= freq_khz;
                  sidx    <= '0;
                  state   <= S_SRCH_RD;
                end
              end
              tsfc_pkg::OP_REEVAL: state <= S_REEVAL;
              default: ;
            endcase
          end
        end
        S_REEVAL: begin
          use_floor <= 1'b0;
          lvl       <= top_level;
          state     <= diff_neg ? S_LVL : S_DIV;
        end
        S_SRCH_RD: state <= S_SRCH_CHK;
        S_SRCH_CHK: begin
          if ((rdata < cap_reg) && (sidx != LW'(TABLE_DEPTH - 1))) begin
            sidx  <= sidx + LW'(1);
            state <= S_SRCH_RD;
          end else begin
            top_level     <= sidx;
            current_level <= '0;
            applied_cap   <= cap_reg;
            state         <= S_REEVAL;
          end
        end
        S_DIV: begin
          if (div_done) begin
            // level = top - (q + 1), clamped at zero
            if (quotient >= DW'(top_level)) begin
              lvl <= '0;
            end else begin
              lvl <= top_level - quotient[LW-1:0] - LW'(1);
            end
            state <= S_LVL;
          end
        end
        S_LVL: begin
          if (emit) begin
            current_level <= lvl;
            state         <= S_RD;
          end else begin
            state <= S_IDLE;
          end
        end
        S_RD: state <= S_OUT;
        S_OUT: begin
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register, loaded when the previous result has been transferred
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_OUT) && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_OUT) && (!out_valid || out_ready)) begin
      cap_freq  <= rdata;
      cap_level <= tsfc_pkg::LEVEL_W'(lvl);
    end
  end

`ifndef SYNTHESIS
  // applied level never rises above the top level of the cap
  a_level_le_top: assert property (@(posedge clk) disable iff (rst)
    current_level <= top_level)
    else $error("current level above top level");

  // divider finishes only while the sequencer waits for it
  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV))
    else $error("divider done outside divide state");

  // table writes happen only on an idle transfer
  a_write_idle: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_IDLE))
    else $error("table write while busy");

  // a pending result holds the sequencer in the output state
  a_out_stall: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) && out_valid && !out_ready |=> (state == S_OUT))
    else $error("result lost under stall");
`endif

endmodule

### test/thermal_step_frequency_cap_unit_test.sv
// ----------------------------------------------------------------------------
// thermal_step_frequency_cap_unit_test
// Self-checking bench for the thermal step frequency cap unit. The frequency
// table is loaded first. Then a directed run covers the corner cases, and
// several register settings follow with random sample, cap, re-evaluate and
// table write traffic. Both channels idle at random, but for one back-to-back
// run. A built-in predictor of the governor computes each expected cap, and
// the monitor checks every result transfer against it in order.
// ----------------------------------------------------------------------------
module thermal_step_frequency_cap_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH          = 16;
  localparam int SETTLE         = 100;   // longer than a full table search plus a divide
  localparam int WATCHDOG_LIMIT = 4000;
  localparam tsfc_pkg::freq_t FREQ_MAX = {tsfc_pkg::FREQ_W{1'b1}};

  typedef struct {
    logic [tsfc_pkg::OPCODE_W-1:0] op;
    logic signed [15:0]            temp;
    tsfc_pkg::freq_t               freq;
    logic [tsfc_pkg::ENTRY_W-1:0]  idx;
  } gov_cmd_t;

  typedef struct {
    tsfc_pkg::freq_t              freq;
    logic [tsfc_pkg::LEVEL_W-1:0] level;
  } cap_result_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            cfg_we = 1'b0;
  logic [tsfc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [tsfc_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic [tsfc_pkg::OPCODE_W-1:0]   opcode = '0;
  logic signed [15:0]              temperature = '0;
  tsfc_pkg::freq_t                 freq_khz = '0;
  logic [tsfc_pkg::ENTRY_W-1:0]    entry_index = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  tsfc_pkg::freq_t                 cap_freq;
  logic [tsfc_pkg::LEVEL_W-1:0]    cap_level;

  // command stream and expected caps
  gov_cmd_t    cmd_queue[$];
  cap_result_t cap_expect[$];
  int          fails = 0;
  logic        in_taken = 1'b0;
  bit          no_idle = 1'b0;
  int          send_gap = 0;
  int          recv_stall = 0;
  int          idle_cycles = 0;

  // governor registers and state as predicted
  bit              gov_enable = 1'b0;
  int              gov_threshold = 0;
  int              gov_step = 1;
  int              gov_floor = 0;
  tsfc_pkg::freq_t cap_table[DEPTH];
  int              pred_level = 0;
  int              top_level = 0;
  tsfc_pkg::freq_t applied_cap = '0;
  int              last_temp = 0;

  // generator shadow, runs ahead of acceptance
  tsfc_pkg::freq_t gen_table[DEPTH];
  int              gen_last_temp = 0;
  tsfc_pkg::freq_t gen_last_cap = '0;

  thermal_step_frequency_cap_unit dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .opcode      (opcode),
    .temperature (temperature),
    .freq_khz    (freq_khz),
    .entry_index (entry_index),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .cap_freq    (cap_freq),
    .cap_level   (cap_level)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic int eff_step();
    return (gov_step == 0) ? 1 : gov_step;
  endfunction

  function automatic void post_level(input int lvl);
    cap_result_t res;
    pred_level = lvl;
    res.freq   = cap_table[lvl];
    res.level  = tsfc_pkg::LEVEL_W'(lvl);
    cap_expect.push_back(res);
  endfunction

  // level from the last temperature, no floor here
  function automatic void reevaluate_level();
    int steps, lvl;
    steps = 0;
    if (last_temp >= gov_threshold) steps = (last_temp - gov_threshold) / eff_step() + 1;
    lvl = top_level - steps;
    if (lvl < 0) lvl = 0;
    if (lvl != pred_level) post_level(lvl);
  endfunction

  function automatic void predict_cap(input gov_cmd_t cmd);
    int d, lvl, idx;
    case (cmd.op)
      tsfc_pkg::OP_SAMPLE: begin
        if (gov_enable && int'(cmd.temp) != last_temp) begin
          last_temp = cmd.temp;
          d = last_temp - gov_threshold;
          if (d < 0) begin
            if (pred_level != top_level) post_level(top_level);
          end else begin
            lvl = top_level - (d / eff_step() + 1);
            if (lvl < 0) lvl = 0;
            if (lvl != pred_level && pred_level >= gov_floor) post_level(lvl);
          end
        end
      end
      tsfc_pkg::OP_NEWCAP: begin
        if (cmd.freq != applied_cap) begin
          idx = 0;
          while (idx < DEPTH - 1 && cap_table[idx] < cmd.freq) idx++;
          pred_level  = 0;
          top_level   = idx;
          applied_cap = cmd.freq;
          reevaluate_level();
        end
      end
      tsfc_pkg::OP_REEVAL: reevaluate_level();
      tsfc_pkg::OP_WRITE:  cap_table[cmd.idx] = cmd.freq;
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------- generation

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic void queue_item(input logic [tsfc_pkg::OPCODE_W-1:0] op,
                                     input logic signed [15:0] temp,
                                     input tsfc_pkg::freq_t freq,
                                     input logic [tsfc_pkg::ENTRY_W-1:0] idx);
    gov_cmd_t cmd;
    cmd.op   = op;
    cmd.temp = temp;
    cmd.freq = freq;
    cmd.idx  = idx;
    if (op == tsfc_pkg::OP_WRITE) gen_table[idx] = freq;
    if (op == tsfc_pkg::OP_SAMPLE) gen_last_temp = temp;
    if (op == tsfc_pkg::OP_NEWCAP) gen_last_cap = freq;
    cmd_queue.push_back(cmd);
  endfunction

  function automatic logic signed [15:0] rand_temp();
    return 16'($urandom);
  endfunction

  function automatic tsfc_pkg::freq_t rand_freq();
    return tsfc_pkg::FREQ_W'($urandom);
  endfunction

  function automatic logic [tsfc_pkg::ENTRY_W-1:0] rand_index();
    return tsfc_pkg::ENTRY_W'($urandom);
  endfunction

  // mostly around the threshold, a few repeats and full-range readings
  function automatic logic signed [15:0] pick_temp();
    int span, t;
    span = eff_step();
    case ($urandom_range(0, 9))
      0: t = int'($urandom_range(0, 65535)) - 32768;
      1: t = gen_last_temp;
      default: t = gov_threshold + (int'($urandom_range(0, 19)) - 3) * span +
                   int'($urandom_range(0, span - 1));
    endcase
    if (t > 32767) t = 32767;
    if (t < -32768) t = -32768;
    return 16'(t);
  endfunction

  function automatic tsfc_pkg::freq_t pick_cap();
    int i;
    i = $urandom_range(0, DEPTH - 1);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return FREQ_MAX;
      2: return gen_last_cap;
      3, 4, 5: return gen_table[i];
      6, 7, 8: return (gen_table[i] == FREQ_MAX) ? FREQ_MAX : gen_table[i] + 1'b1;
      default: return rand_freq();
    endcase
  endfunction

  // ---------------------------------------------------------------- sequencing

  task automatic write_reg(input logic [tsfc_pkg::CFG_IDX_W-1:0] index, input int value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= tsfc_pkg::CFG_DATA_W'(value);
    @(negedge clk);
    cfg_we <= 1'b0;
    case (index)
      tsfc_pkg::CFG_ENABLE:    gov_enable = value[0];
      tsfc_pkg::CFG_THRESHOLD: gov_threshold = $signed(value[15:0]);
      tsfc_pkg::CFG_STEP:      gov_step = value[14:0];
      tsfc_pkg::CFG_FLOOR:     gov_floor = value[3:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input int en, input int thr, input int step, input int floor_lvl);
    write_reg(tsfc_pkg::CFG_ENABLE, en);
    write_reg(tsfc_pkg::CFG_THRESHOLD, thr);
    write_reg(tsfc_pkg::CFG_STEP, step);
    write_reg(tsfc_pkg::CFG_FLOOR, floor_lvl);
  endtask

  // hold off until every command is taken and every cap has come back
  task automatic drain();
    while (cmd_queue.size() != 0 || in_valid) @(posedge clk);
    while (cap_expect.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic run_traffic(input int count);
    int n, r, idx;
    tsfc_pkg::freq_t lo, hi, val;
    for (n = 0; n < count; n++) begin
      if (n == count / 2) drain();
      r = $urandom_range(0, 99);
      if (r < 55) begin
        queue_item(tsfc_pkg::OP_SAMPLE, pick_temp(), rand_freq(), rand_index());
      end else if (r < 72) begin
        queue_item(tsfc_pkg::OP_NEWCAP, rand_temp(), pick_cap(), rand_index());
      end else if (r < 82) begin
        queue_item(tsfc_pkg::OP_REEVAL, rand_temp(), rand_freq(), rand_index());
      end else if (r < 92) begin
        // mostly keep the table sorted
        idx = $urandom_range(0, DEPTH - 1);
        lo  = (idx == 0) ? tsfc_pkg::freq_t'(0) : gen_table[idx - 1];
        hi  = (idx == DEPTH - 1) ? FREQ_MAX : gen_table[idx + 1];
        if (hi >= lo && $urandom_range(0, 9) < 7) begin
          val = lo + tsfc_pkg::FREQ_W'($urandom_range(0, hi - lo));
        end else begin
          val = rand_freq();
        end
        queue_item(tsfc_pkg::OP_WRITE, rand_temp(), val, tsfc_pkg::ENTRY_W'(idx));
      end else begin
        queue_item(tsfc_pkg::OPCODE_W'($urandom_range(0, 3)), rand_temp(), rand_freq(),
                   rand_index());
      end
    end
  endtask

  initial begin : stimulus
    int i;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    set_config(1, 0, 1, 0);

    // ascending table with the zero and near-top extremes
    for (i = 0; i < DEPTH; i++)
      queue_item(tsfc_pkg::OP_WRITE, rand_temp(),
                 (i == 0) ? tsfc_pkg::freq_t'(0) :
                            tsfc_pkg::FREQ_W'(i * 262000 + $urandom_range(0, 261999)),
                 tsfc_pkg::ENTRY_W'(i));
    // same as applied cap, then above every entry
    queue_item(tsfc_pkg::OP_NEWCAP, rand_temp(), '0, rand_index());
    queue_item(tsfc_pkg::OP_NEWCAP, rand_temp(), FREQ_MAX, rand_index());
    // same as last reading
    queue_item(tsfc_pkg::OP_SAMPLE, 16'sd0, rand_freq(), rand_index());
    queue_item(tsfc_pkg::OP_SAMPLE, 16'sh8000, rand_freq(), rand_index());
    queue_item(tsfc_pkg::OP_SAMPLE, 16'sh7fff, rand_freq(), rand_index());
    queue_item(tsfc_pkg::OP_SAMPLE, 16'sh7fff, rand_freq(), rand_index());
    // right at threshold
    queue_item(tsfc_pkg::OP_SAMPLE, 16'sd0, rand_freq(), rand_index());
    queue_item(tsfc_pkg::OP_SAMPLE, 16'sd5, rand_freq(), rand_index());
    queue_item(tsfc_pkg::OP_REEVAL, rand_temp(), rand_freq(), rand_index());
    queue_item(tsfc_pkg::OP_WRITE, rand_temp(), FREQ_MAX, 4'd15);
    queue_item(tsfc_pkg::OP_NEWCAP, rand_temp(), FREQ_MAX, rand_index());
    queue_item(tsfc_pkg::OP_NEWCAP, rand_temp(), gen_table[7], rand_index());
    queue_item(tsfc_pkg::OP_SAMPLE, -16'sd1, rand_freq(), rand_index());
    queue_item(tsfc_pkg::OP_SAMPLE, 16'sd3, rand_freq(), rand_index());
    queue_item(tsfc_pkg::OP_REEVAL, rand_temp(), rand_freq(), rand_index());
    drain();

    // back-to-back traffic, no idling on either side
    no_idle = 1'b1;
    set_config(1, -5, 3, 0);
    run_traffic(150);
    drain();
    no_idle = 1'b0;

    // register extremes
    set_config(1, -32768, 32767, 15);
    run_traffic(100);
    drain();

    // zero step acts as one, with a random floor
    set_config(1, int'($urandom_range(0, 200)) - 100, 0, $urandom_range(0, 6));
    run_traffic(150);
    drain();

    // governor off: samples ignored, other commands still run
    set_config(0, int'($urandom_range(0, 200)) - 100, $urandom_range(1, 8), 0);
    run_traffic(100);
    drain();

    set_config(1, 32767, 1, 0);
    run_traffic(60);
    drain();

    set_config(1, int'($urandom_range(0, 65535)) - 32768, $urandom_range(1, 32767),
               $urandom_range(0, 15));
    run_traffic(100);
    drain();

    set_config(1, int'($urandom_range(0, 100)) - 50, $urandom_range(1, 10),
               $urandom_range(0, 4));
    run_traffic(200);
    drain();

    if (fails == 0) begin
      $display("thermal_step_frequency_cap_unit_test OK");
    end else begin
      $display("thermal_step_frequency_cap_unit_test NOT OK");
    end
    $finish;
  end

  // ---------------------------------------------------------------- driver

  // command side, changes at the falling edge
  always @(negedge clk) begin : cmd_driver
    gov_cmd_t cmd;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (cmd_queue.size() != 0) begin
        cmd = cmd_queue.pop_front();
        opcode      <= cmd.op;
        temperature <= cmd.temp;
        freq_khz    <= cmd.freq;
        entry_index <= cmd.idx;
        in_valid    <= 1'b1;
        send_gap = pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side backpressure
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (recv_stall > 0) begin
      out_ready <= 1'b0;
      recv_stall--;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) recv_stall = pick_gap();
    end
  end

  // ---------------------------------------------------------------- monitor

  // check result transfers, then predict from the accepted command
  always @(posedge clk) begin : cap_monitor
    cap_result_t want;
    gov_cmd_t    cmd;
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        if (cap_expect.size() == 0) begin
          $error("unexpected result: cap_freq %0d cap_level %0d", cap_freq, cap_level);
          fails++;
        end else begin
          want = cap_expect.pop_front();
          if (cap_freq !== want.freq) begin
            $error("cap_freq: expected %0d, got %0d", want.freq, cap_freq);
            fails++;
          end
          if (cap_level !== want.level) begin
            $error("cap_level: expected %0d, got %0d", want.level, cap_level);
            fails++;
          end
        end
      end
      if (in_valid && in_ready) begin
        cmd.op   = opcode;
        cmd.temp = temperature;
        cmd.freq = freq_khz;
        cmd.idx  = entry_index;
        predict_cap(cmd);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("thermal_step_frequency_cap_unit_test NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

### sim.f
hw/rtl/tsfc_pkg.sv
hw/rtl/tsfc_ram.sv
hw/rtl/tsfc_div.sv
hw/rtl/thermal_step_frequency_cap_unit.sv
test/thermal_step_frequency_cap_unit_test.sv
